FILE: design/oot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oot_pkg
// Shared constants and types of the oriented box overlap test unit.
// ----------------------------------------------------------------------------
package oot_pkg;

    localparam int COORD_BITS_DEF = 21;
    localparam int WORD_W         = 63;
    localparam int NUM_WORDS      = 5;
    localparam int IN_DATA_W      = 320;
    localparam int OUT_DATA_W     = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_AXES       = 15;
    localparam int CODE_W         = 4;
    localparam int LAT            = 8;

    localparam logic [CODE_W-1:0] CODE_NONE = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_CENTER = 3'd0,
        CFG_A_HALF   = 3'd1,
        CFG_A_AXIS_X = 3'd2,
        CFG_A_AXIS_Y = 3'd3,
        CFG_A_AXIS_Z = 3'd4
    } t_cfg_idx;

endpackage

FILE: design/obb_obb_overlap_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_unit
// Separating axis overlap test of a streamed box B against a configured box A.
// ----------------------------------------------------------------------------
// The user must write box A through the plain register port (i_cfg_we,
// i_cfg_idx, i_cfg_data) only while the unit is idle; the block does not
// enforce this. Each input item on the s_axis channel carries box B; each
// output item on m_axis carries the overlap flag and the code of the first
// separating axis, or 15 when none separates. All 15 axes are tested in
// parallel lanes. Three stages build the cross product axes, five stages in
// each lane form products, dot magnitudes, radius terms and the comparison,
// and one output register holds the encoded result.
// One item is accepted every cycle while the output is taken.
// A synchronous reset clears the valid bits and the box A registers.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module obb_obb_overlap_test_unit #(
    parameter int COORD_BITS = oot_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // b_center, b_half_extent, b_axis_x, b_axis_y, b_axis_z (63 bits each).
    input  logic [oot_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // overlap, separating_axis.
    output logic [oot_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [oot_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [oot_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int N   = COORD_BITS;
    localparam int W   = oot_pkg::WORD_W;
    localparam int XW  = 2 * N + 1;

    logic [W-1:0] r_acfg [5];
    logic [W-1:0] r_s1   [5];
    logic [W-1:0] r_s2   [5];
    logic [W-1:0] r_s3   [5];
    logic signed [N:0]     r_d2 [3];
    logic signed [N:0]     r_d3 [3];
    logic signed [2*N-1:0] r_cp [9][6];
    logic signed [XW-1:0]  r_cl [9][3];
    logic [oot_pkg::LAT-1:0]    r_vld;
    logic                       r_out_valid;
    logic [oot_pkg::CODE_W-1:0] r_code;

    logic en;
    logic acc;
    logic signed [N-1:0] a_c  [3];
    logic signed [N-1:0] a_ax [3][3];
    logic signed [N-1:0] b1_c [3];
    logic signed [N-1:0] b1_ax[3][3];
    logic signed [N-1:0] b3_ax[3][3];
    logic signed [N-1:0] lane_ax [6][3];
    logic        [N-1:0] hmag [6];
    logic signed [N-1:0] hraw [6];
    logic [oot_pkg::NUM_AXES-1:0] sep;
    logic [oot_pkg::CODE_W-1:0]   n_code;

    assign en            = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid & en;

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            a_c[m]  = r_acfg[0][m*N +: N];
            b1_c[m] = r_s1[0][m*N +: N];
            hraw[m]     = r_acfg[1][m*N +: N];
            hraw[m + 3] = r_s3[1][m*N +: N];
            for (int k = 0; k < 3; k++) begin
                a_ax[k][m]  = r_acfg[k+2][m*N +: N];
                b1_ax[k][m] = r_s1[k+2][m*N +: N];
                b3_ax[k][m] = r_s3[k+2][m*N +: N];
                lane_ax[k][m]     = a_ax[k][m];
                lane_ax[k + 3][m] = b3_ax[k][m];
            end
        end
        for (int k = 0; k < 6; k++) begin
            hmag[k] = hraw[k][N-1] ? N'(-hraw[k]) : N'(hraw[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_acfg[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                oot_pkg::CFG_A_CENTER: r_acfg[0] <= i_cfg_data;
                oot_pkg::CFG_A_HALF:   r_acfg[1] <= i_cfg_data;
                oot_pkg::CFG_A_AXIS_X: r_acfg[2] <= i_cfg_data;
                oot_pkg::CFG_A_AXIS_Y: r_acfg[3] <= i_cfg_data;
                oot_pkg::CFG_A_AXIS_Z: r_acfg[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[oot_pkg::LAT-2:0], acc};
            r_out_valid <= r_vld[oot_pkg::LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 5; k++) begin
                r_s1[k] <= s_axis_tdata[k*W +: W];
                r_s2[k] <= r_s1[k];
                r_s3[k] <= r_s2[k];
            end
            for (int m = 0; m < 3; m++) begin
                r_d2[m] <= (N+1)'(b1_c[m]) - (N+1)'(a_c[m]);
                r_d3[m] <= r_d2[m];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_cp[3*i+j][0] <= (2*N)'(a_ax[i][1]) * (2*N)'(b1_ax[j][2]);
                    r_cp[3*i+j][1] <= (2*N)'(a_ax[i][2]) * (2*N)'(b1_ax[j][1]);
                    r_cp[3*i+j][2] <= (2*N)'(a_ax[i][2]) * (2*N)'(b1_ax[j][0]);
                    r_cp[3*i+j][3] <= (2*N)'(a_ax[i][0]) * (2*N)'(b1_ax[j][2]);
                    r_cp[3*i+j][4] <= (2*N)'(a_ax[i][0]) * (2*N)'(b1_ax[j][1]);
                    r_cp[3*i+j][5] <= (2*N)'(a_ax[i][1]) * (2*N)'(b1_ax[j][0]);
                end
            end
            for (int c = 0; c < 9; c++) begin
                for (int m = 0; m < 3; m++) begin
                    r_cl[c][m] <= XW'(r_cp[c][2*m]) - XW'(r_cp[c][2*m+1]);
                end
            end
            r_code <= n_code;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 6; g++) begin : g_face
            oot_lane #(.N(N), .LW(N)) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_l    (lane_ax[g]),
                .i_d    (r_d3),
                .i_ax   (lane_ax),
                .i_hmag (hmag),
                .o_sep  (sep[g])
            );
        end
        for (g = 0; g < 9; g++) begin : g_cross
            oot_lane #(.N(N), .LW(XW)) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_l    (r_cl[g]),
                .i_d    (r_d3),
                .i_ax   (lane_ax),
                .i_hmag (hmag),
                .o_sep  (sep[g + 6])
            );
        end
    endgenerate

    always_comb begin
        n_code = oot_pkg::CODE_NONE;
        for (int k = oot_pkg::NUM_AXES - 1; k >= 0; k--) begin
            if (sep[k]) begin
                n_code = oot_pkg::CODE_W'(k);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_code, r_code == oot_pkg::CODE_NONE};

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    a_flag_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[4:1] == oot_pkg::CODE_NONE)))
        else $error("overlap flag disagrees with axis code");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_last_stage_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[oot_pkg::LAT-1]) |=> m_axis_tvalid)
        else $error("item lost between last stage and output register");

endmodule

FILE: design/oot_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oot_lane
// Five-stage test of one candidate axis: projected radii and centre distance.
// ----------------------------------------------------------------------------
module oot_lane #(
    parameter int N  = oot_pkg::COORD_BITS_DEF,
    parameter int LW = oot_pkg::COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [LW-1:0] i_l    [3],
    input  logic signed [N:0]    i_d    [3],
    input  logic signed [N-1:0]  i_ax   [6][3],
    input  logic        [N-1:0]  i_hmag [6],
    output logic                 o_sep
);

    localparam int PW   = N + LW;
    localparam int DW   = PW + 2;
    localparam int HALF = (DW + 1) / 2;
    localparam int HW   = DW - HALF;
    localparam int RTW  = DW + N;
    localparam int RW   = RTW + 3;
    localparam int DPW  = N + 1 + LW;
    localparam int DSW  = DPW + 2;
    localparam int DSHW = DSW + N - 2;
    localparam int CW   = ((RW > DSHW) ? RW : DSHW) + 1;

    logic signed [PW-1:0]    r_p  [6][3];
    logic signed [DPW-1:0]   r_q  [3];
    logic        [N-1:0]     r_h1 [6];
    logic        [DW-1:0]    r_m  [6];
    logic        [DSW-1:0]   r_dm;
    logic        [N-1:0]     r_h2 [6];
    logic        [HALF+N-1:0] r_lo [6];
    logic        [HW+N-1:0]  r_hi [6];
    logic        [DSHW-1:0]  r_ds3;
    logic        [RTW-1:0]   r_t  [6];
    logic        [DSHW-1:0]  r_ds4;
    logic                    r_sep;

    logic signed [DW-1:0]    dot  [6];
    logic signed [DSW-1:0]   dsum;
    logic        [RW-1:0]    rad;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            dot[k] = DW'(r_p[k][0]) + DW'(r_p[k][1]) + DW'(r_p[k][2]);
        end
        dsum = DSW'(r_q[0]) + DSW'(r_q[1]) + DSW'(r_q[2]);
        rad = '0;
        for (int k = 0; k < 6; k++) begin
            rad = rad + RW'(r_t[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                for (int m = 0; m < 3; m++) begin
                    r_p[k][m] <= PW'(i_ax[k][m]) * PW'(i_l[m]);
                end
                r_h1[k] <= i_hmag[k];
            end
            for (int m = 0; m < 3; m++) begin
                r_q[m] <= DPW'(i_d[m]) * DPW'(i_l[m]);
            end
            for (int k = 0; k < 6; k++) begin
                r_m[k]  <= dot[k][DW-1] ? DW'(-dot[k]) : DW'(dot[k]);
                r_h2[k] <= r_h1[k];
            end
            r_dm <= dsum[DSW-1] ? DSW'(-dsum) : DSW'(dsum);
            for (int k = 0; k < 6; k++) begin
                r_lo[k] <= (HALF+N)'(r_m[k][HALF-1:0]) * (HALF+N)'(r_h2[k]);
                r_hi[k] <= (HW+N)'(r_m[k][DW-1:HALF]) * (HW+N)'(r_h2[k]);
            end
            r_ds3 <= DSHW'(r_dm) << (N - 2);
            for (int k = 0; k < 6; k++) begin
                r_t[k] <= RTW'(r_lo[k]) + (RTW'(r_hi[k]) << HALF);
            end
            r_ds4 <= r_ds3;
            r_sep <= CW'(r_ds4) > CW'(rad);
        end
    end

    assign o_sep = r_sep;

endmodule
